/* hdl/euclidean_interest_range_tracker_core_macros.svh */
// Assertion macros used by the tracker top level.
// No dependencies.
`ifndef EUCLIDEAN_INTEREST_RANGE_TRACKER_CORE_MACROS_SVH
`define EUCLIDEAN_INTEREST_RANGE_TRACKER_CORE_MACROS_SVH
// implication checked on every clock while out of reset
`define EIRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define EIRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

/* hdl/eirt_pkg.sv */
// Package for the interest range tracker: sizes, codes, cell bus type.
// No dependencies.
package eirt_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int COORD_BITS  = 16;
	localparam int ID_BITS     = 16;
	localparam int RAD_BITS    = 15;
	localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS     = 2 * DIFF_BITS + 1;

	localparam logic [2:0] OP_ADD_PUB = 3'd0;
	localparam logic [2:0] OP_ADD_SUB = 3'd1;
	localparam logic [2:0] OP_REM_PUB = 3'd2;
	localparam logic [2:0] OP_REM_SUB = 3'd3;
	localparam logic [2:0] OP_MOV_PUB = 3'd4;
	localparam logic [2:0] OP_MOV_SUB = 3'd5;

	localparam logic [1:0] EV_ADD    = 2'd0;
	localparam logic [1:0] EV_REMOVE = 2'd1;
	localparam logic [1:0] EV_MOVE   = 2'd2;
	localparam logic [1:0] EV_DONE   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic                  wr_pub;
		logic                  wr_sub;
		logic                  clr_pub;
		logic                  clr_sub;
		logic                  mov_pub;
		logic                  mov_sub;
		logic [SLOT_BITS-1:0]  slot;
		logic [ID_BITS-1:0]    id;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [RAD_BITS-1:0]   r;
	} eirt_cmd_t;

	// entry handed from cell to cell during a scan
	typedef struct packed {
		logic                  pv;
		logic [ID_BITS-1:0]    pid;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic                  sv;
		logic [ID_BITS-1:0]    sid;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [RAD_BITS-1:0]   sr;
	} eirt_ent_t;
endpackage

/* hdl/euclidean_interest_range_tracker_core.sv */
// Top level of the interest range tracker: controller, cell ring, range test.
// Depends on eirt_pkg, eirt_cell, eirt_dist and the macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_ready  | opcode entity_id pos_x pos_y old_x old_y view_range
//  out      | out_valid / out_ready| peer_id event_kind status last
//
// An item runs: a lookup state, then per event group one full ring
// rotation plus a pipeline drain, then done. Add and remove scan one
// group, pub move three (enter, leave, move), sub move two (enter,
// leave); an item that scans nothing (full, unknown id on remove,
// undefined opcode) goes from lookup straight to done.
// Output stalls freeze the ring and the range pipeline in place.
// Reset empties both tables (valid bits only) and idles the controller.
// One item at a time; in_ready is high only between items.
module euclidean_interest_range_tracker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] entity_id,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] old_x,
	input  logic signed [15:0] old_y,
	input  logic [14:0] view_range,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] peer_id,
	output logic [1:0]  event_kind,
	output logic [1:0]  status,
	output logic        last
);
	import eirt_pkg::*;
	`include "euclidean_interest_range_tracker_core_macros.svh"

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_DRAIN, S_DONE} st_t;
	localparam int CNT_BITS = SLOT_BITS + 1;
	localparam int LAT = 4;

	st_t st_q;
	logic [2:0] op_q;
	logic [ID_BITS-1:0] id_q;
	logic [COORD_BITS-1:0] nx_q, ny_q, ox_q, oy_q;
	logic [RAD_BITS-1:0] r_q;
	logic [1:0] pass_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [2:0] drn_q;
	logic [1:0] st_res_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic found_q;

	eirt_ent_t ents [TABLE_DEPTH];
	eirt_cmd_t cmd;
	logic [TABLE_DEPTH-1:0] sel;
	logic rot, stall;

	// ring: cell i takes from cell i+1, the last cell from cell 0, so the
	// head sees slots in ascending order
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		eirt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .rot(rot), .sel(sel[g]), .cmd(cmd),
			.prev(ents[(g + 1) % TABLE_DEPTH]), .ent(ents[g])
		);
	end

	// lookup: exact match on id, else lowest free slot (priority search)
	logic is_pub;
	logic m_found, f_found;
	logic [SLOT_BITS-1:0] m_slot, f_slot;
	assign is_pub = (op_q == OP_ADD_PUB) || (op_q == OP_REM_PUB) || (op_q == OP_MOV_PUB);
	always_comb begin
		m_found = 1'b0; f_found = 1'b0;
		m_slot = '0; f_slot = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (is_pub ? (ents[i].pv && ents[i].pid == id_q)
			           : (ents[i].sv && ents[i].sid == id_q)) begin
				m_found = 1'b1; m_slot = SLOT_BITS'(i);
			end
			if (!(is_pub ? ents[i].pv : ents[i].sv)) begin
				f_found = 1'b1; f_slot = SLOT_BITS'(i);
			end
		end
	end

	// scan head: entry in cell 0 is compared each rotation step
	eirt_ent_t h;
	assign h = ents[0];
	logic scan_pub;  // true when the scanned table is subscribers (pub op)
	assign scan_pub = is_pub;
	logic peer_ok;
	logic [COORD_BITS-1:0] qx, qy, px, py;
	logic [RAD_BITS-1:0] qr;
	always_comb begin
		peer_ok = scan_pub ? (h.sv && h.sid != id_q) : (h.pv && h.pid != id_q);
		px = scan_pub ? h.sx : h.px;
		py = scan_pub ? h.sy : h.py;
		qr = scan_pub ? h.sr : r_q;
		qx = nx_q; qy = ny_q;
		unique case (op_q)
			OP_REM_PUB, OP_REM_SUB: begin
				qx = ox_q; qy = oy_q;
				if (op_q == OP_REM_SUB) qr = r_q;
			end
			default: ;
		endcase
	end

	logic scan_vld;
	assign scan_vld = (st_q == S_SCAN) && !stall;
	logic hit_n, hit_o;
	eirt_dist u_dn (.clk(clk), .arst_n(arst_n), .en(!stall),
		.ax($signed(qx)), .ay($signed(qy)), .bx($signed(px)), .by($signed(py)),
		.r(qr), .ok_in(peer_ok), .hit(hit_n));
	eirt_dist u_do (.clk(clk), .arst_n(arst_n), .en(!stall),
		.ax($signed(ox_q)), .ay($signed(oy_q)), .bx($signed(px)), .by($signed(py)),
		.r(qr), .ok_in(peer_ok), .hit(hit_o));

	// peer id and valid-flag delayed alongside the range pipeline
	logic [ID_BITS-1:0] pid_s1, pid_s2, pid_s3;
	logic v_s1, v_s2, v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= scan_vld; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (!stall) begin
			pid_s1 <= scan_pub ? h.sid : h.pid;
			pid_s2 <= pid_s1; pid_s3 <= pid_s2;
		end
	end

	// event decision per pass
	logic emit;
	logic [1:0] kind;
	always_comb begin
		emit = 1'b0; kind = EV_ADD;
		unique case (op_q)
			OP_ADD_PUB, OP_ADD_SUB: begin emit = hit_n; kind = EV_ADD; end
			OP_REM_PUB, OP_REM_SUB: begin emit = hit_n; kind = EV_REMOVE; end
			OP_MOV_PUB, OP_MOV_SUB: begin
				unique case (pass_q)
					2'd0: begin emit = hit_n && !hit_o; kind = EV_ADD; end
					2'd1: begin emit = !hit_n && hit_o; kind = EV_REMOVE; end
					default: begin emit = hit_n && hit_o; kind = EV_MOVE; end
				endcase
			end
			default: ;
		endcase
		emit = emit && v_s3;
	end

	assign stall = out_valid && !out_ready;
	assign rot = (st_q == S_SCAN) && !stall;
	assign in_ready = (st_q == S_IDLE);

	// table write command, issued in the done state when out is free
	logic do_wr;
	assign do_wr = (st_q == S_DONE) && !stall;
	// output register takes a new item this cycle
	logic load_out;
	assign load_out = (!stall && emit) || do_wr;
	always_comb begin
		cmd = '0;
		cmd.slot = slot_q; cmd.id = id_q; cmd.x = nx_q; cmd.y = ny_q; cmd.r = r_q;
		if (do_wr && found_q) begin
			unique case (op_q)
				OP_ADD_PUB: cmd.wr_pub  = 1'b1;
				OP_ADD_SUB: cmd.wr_sub  = 1'b1;
				OP_REM_PUB: cmd.clr_pub = 1'b1;
				OP_REM_SUB: cmd.clr_sub = 1'b1;
				OP_MOV_PUB: cmd.mov_pub = 1'b1;
				OP_MOV_SUB: cmd.mov_sub = 1'b1;
				default: ;
			endcase
		end
	end
	always_comb begin
		sel = '0;
		sel[cmd.slot] = 1'b1;
	end

	logic [1:0] npass;
	assign npass = (op_q == OP_MOV_PUB) ? 2'd3 : (op_q == OP_MOV_SUB) ? 2'd2 : 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0; pass_q <= '0; cnt_q <= '0; drn_q <= '0;
			found_q <= 1'b0; st_res_q <= ST_OK; slot_q <= '0; op_q <= '0;
			id_q <= '0; nx_q <= '0; ny_q <= '0; ox_q <= '0; oy_q <= '0; r_q <= '0;
			peer_id <= '0; event_kind <= EV_ADD; status <= ST_OK; last <= 1'b0;
		end else begin
			if (out_valid && out_ready && !load_out) out_valid <= 1'b0;
			if (!stall && emit) begin
				out_valid <= 1'b1; peer_id <= pid_s3; event_kind <= kind;
				status <= ST_OK; last <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					op_q <= opcode; id_q <= entity_id; nx_q <= pos_x; ny_q <= pos_y;
					ox_q <= old_x; oy_q <= old_y; r_q <= view_range;
					st_q <= S_LOOK;
				end
				S_LOOK: begin
					pass_q <= '0; cnt_q <= '0;
					unique case (op_q)
						OP_ADD_PUB, OP_ADD_SUB: begin
							found_q <= m_found || f_found;
							slot_q <= m_found ? m_slot : f_slot;
							if (!m_found && !f_found) begin
								st_res_q <= ST_FULL; st_q <= S_DONE;
							end else begin
								st_res_q <= ST_OK; st_q <= S_SCAN;
							end
						end
						OP_REM_PUB, OP_REM_SUB: begin
							found_q <= m_found; slot_q <= m_slot;
							if (!m_found) begin
								st_res_q <= ST_NOTFOUND; st_q <= S_DONE;
							end else begin
								st_res_q <= ST_OK; st_q <= S_SCAN;
								// scan from the stored position and radius
								ox_q <= is_pub ? ents[m_slot].px : ents[m_slot].sx;
								oy_q <= is_pub ? ents[m_slot].py : ents[m_slot].sy;
								if (!is_pub) r_q <= ents[m_slot].sr;
							end
						end
						OP_MOV_PUB, OP_MOV_SUB: begin
							found_q <= m_found; slot_q <= m_slot;
							st_res_q <= m_found ? ST_OK : ST_NOTFOUND;
							st_q <= S_SCAN;
						end
						default: begin
							found_q <= 1'b0; st_res_q <= ST_OK; st_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: if (!stall) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(TABLE_DEPTH - 1)) begin
						st_q <= S_DRAIN; drn_q <= '0;
					end
				end
				S_DRAIN: if (!stall) begin
					drn_q <= drn_q + 1'b1;
					if (drn_q == 3'(LAT - 1)) begin
						if (pass_q + 2'd1 == npass) st_q <= S_DONE;
						else begin
							pass_q <= pass_q + 2'd1; cnt_q <= '0; st_q <= S_SCAN;
						end
					end
				end
				S_DONE: if (!stall) begin
					out_valid <= 1'b1; peer_id <= '0; event_kind <= EV_DONE;
					status <= st_res_q; last <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`EIRT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable({peer_id, event_kind, status, last}))
	`EIRT_ASSERT_NXT(a_acc_look, clk, arst_n, in_valid && in_ready, st_q == S_LOOK)
	`EIRT_ASSERT_IMP(a_emit_scan, clk, arst_n, emit, st_q == S_SCAN || st_q == S_DRAIN)
	`EIRT_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1,
		$onehot0({cmd.wr_pub, cmd.wr_sub, cmd.clr_pub, cmd.clr_sub, cmd.mov_pub, cmd.mov_sub}))
endmodule

/* hdl/eirt_cell.sv */
// One table slot: holds a publisher and a subscriber entry, rotates them
// along the ring during a scan. Depends on eirt_pkg.
module eirt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rot,
	input  logic                sel,
	input  eirt_pkg::eirt_cmd_t cmd,
	input  eirt_pkg::eirt_ent_t prev,
	output eirt_pkg::eirt_ent_t ent
);
	import eirt_pkg::*;
	eirt_ent_t e_q;
	assign ent = e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q.pv <= 1'b0;
			e_q.sv <= 1'b0;
		end else if (rot) begin
			e_q <= prev;
		end else if (sel) begin
			if (cmd.wr_pub) begin
				e_q.pv <= 1'b1; e_q.pid <= cmd.id; e_q.px <= cmd.x; e_q.py <= cmd.y;
			end
			if (cmd.mov_pub) begin
				e_q.px <= cmd.x; e_q.py <= cmd.y;
			end
			if (cmd.clr_pub) e_q.pv <= 1'b0;
			if (cmd.wr_sub) begin
				e_q.sv <= 1'b1; e_q.sid <= cmd.id;
				e_q.sx <= cmd.x; e_q.sy <= cmd.y; e_q.sr <= cmd.r;
			end
			if (cmd.mov_sub) begin
				e_q.sx <= cmd.x; e_q.sy <= cmd.y; e_q.sr <= cmd.r;
			end
			if (cmd.clr_sub) e_q.sv <= 1'b0;
		end
	end
endmodule

/* hdl/eirt_dist.sv */
// Pipelined range test: three stages, absolute differences, square terms, then sum and compare.
// Depends on eirt_pkg.
module eirt_dist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [eirt_pkg::COORD_BITS-1:0] ax,
	input  logic signed [eirt_pkg::COORD_BITS-1:0] ay,
	input  logic signed [eirt_pkg::COORD_BITS-1:0] bx,
	input  logic signed [eirt_pkg::COORD_BITS-1:0] by,
	input  logic [eirt_pkg::RAD_BITS-1:0] r,
	input  logic                          ok_in,
	output logic                          hit
);
	import eirt_pkg::*;
	logic [DIFF_BITS-1:0] ux_s1, uy_s1;
	logic [RAD_BITS-1:0] r_s1;
	logic ok_s1, ok_s2;
	logic [2*DIFF_BITS-1:0] xx_s2, yy_s2;
	logic [2*RAD_BITS-1:0] rr_s2;
	logic signed [DIFF_BITS-1:0] dx, dy;
	logic [SQ_BITS-1:0] sum;

	assign dx = DIFF_BITS'(ax) - DIFF_BITS'(bx);
	assign dy = DIFF_BITS'(ay) - DIFF_BITS'(by);
	assign sum = SQ_BITS'(xx_s2) + SQ_BITS'(yy_s2);

	// whole pipeline holds while en is low
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
			uy_s1 <= dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
			r_s1  <= r;
			ok_s1 <= ok_in;
			xx_s2 <= ux_s1 * ux_s1;
			yy_s2 <= uy_s1 * uy_s1;
			rr_s2 <= r_s1 * r_s1;
			ok_s2 <= ok_s1;
			hit   <= ok_s2 && (sum <= SQ_BITS'(rr_s2));
		end
	end
	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

/* tb/sv/tb_top.sv */
// Testbench for the interest range tracker: random and directed operations,
// checks every event and done result against a behavioral table model.
// Depends on eirt_pkg and euclidean_interest_range_tracker_core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import eirt_pkg::*;

	typedef struct {
		logic [2:0]         op;
		logic [15:0]        id;
		logic signed [15:0] nx, ny, ox, oy;
		logic [14:0]        rad;
	} op_item_t;

	typedef struct {
		logic [15:0] peer;
		logic [1:0]  kind;
		logic [1:0]  st;
		logic        fin;
	} event_t;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic [2:0] opcode = '0;
	logic [15:0] entity_id = '0;
	logic signed [15:0] pos_x = '0, pos_y = '0, old_x = '0, old_y = '0;
	logic [14:0] view_range = '0;
	logic out_valid, out_ready = 0;
	logic [15:0] peer_id;
	logic [1:0] event_kind, status;
	logic last;

	always #2 clk = ~clk;

	euclidean_interest_range_tracker_core dut (.*);

	// shadow tables
	bit          pv[TABLE_DEPTH], sv[TABLE_DEPTH];
	logic [15:0] pid[TABLE_DEPTH], sid[TABLE_DEPTH];
	longint      px[TABLE_DEPTH], py[TABLE_DEPTH], sx[TABLE_DEPTH], sy[TABLE_DEPTH];
	longint      sr[TABLE_DEPTH];

	op_item_t pending_ops[$];
	event_t   expected_events[$];
	int       mismatches = 0;
	bit       quiet = 0;   // no idling in the final stretch
	bit       stim_done = 0;
	int       idle_cycles = 0;

	function automatic void queue_op(op_item_t t);
		pending_ops.insert(pending_ops.size(), t);
	endfunction

	function automatic void expect_ev(event_t e);
		expected_events.insert(expected_events.size(), e);
	endfunction

	function automatic bit near(longint ax, longint ay, longint bx, longint by, longint r);
		longint dx, dy;
		dx = ax - bx;
		dy = ay - by;
		return dx * dx + dy * dy <= r * r;
	endfunction

	function automatic bit sub_sees(int i, logic [15:0] id, longint x, longint y);
		return sv[i] && sid[i] != id && near(x, y, sx[i], sy[i], sr[i]);
	endfunction

	function automatic bit pub_seen(int i, logic [15:0] id, longint x, longint y, longint r);
		return pv[i] && pid[i] != id && near(x, y, px[i], py[i], r);
	endfunction

	function automatic void push_ev(logic [15:0] peer, logic [1:0] kind);
		event_t e;
		e.peer = peer; e.kind = kind; e.st = ST_OK; e.fin = 0;
		expect_ev(e);
	endfunction

	// Apply one operation to the shadow tables and queue its events.
	function automatic void predict_tracker(op_item_t t);
		int s;
		logic [1:0] st;
		longint nx, ny, ox, oy, r;
		event_t d;
		nx = t.nx; ny = t.ny; ox = t.ox; oy = t.oy; r = t.rad;
		st = ST_OK;
		s = -1;
		case (t.op)
			OP_ADD_PUB, OP_REM_PUB, OP_MOV_PUB: begin
				foreach (pv[i]) if (s < 0 && pv[i] && pid[i] == t.id) s = i;
			end
			OP_ADD_SUB, OP_REM_SUB, OP_MOV_SUB: begin
				foreach (sv[i]) if (s < 0 && sv[i] && sid[i] == t.id) s = i;
			end
			default: ;
		endcase
		case (t.op)
			OP_ADD_PUB: begin
				if (s < 0) foreach (pv[i]) if (s < 0 && !pv[i]) s = i;
				if (s < 0) st = ST_FULL;
				else begin
					pv[s] = 1; pid[s] = t.id; px[s] = nx; py[s] = ny;
					foreach (sv[i]) if (sub_sees(i, t.id, nx, ny)) push_ev(sid[i], EV_ADD);
				end
			end
			OP_ADD_SUB: begin
				if (s < 0) foreach (sv[i]) if (s < 0 && !sv[i]) s = i;
				if (s < 0) st = ST_FULL;
				else begin
					sv[s] = 1; sid[s] = t.id; sx[s] = nx; sy[s] = ny; sr[s] = r;
					foreach (pv[i]) if (pub_seen(i, t.id, nx, ny, r)) push_ev(pid[i], EV_ADD);
				end
			end
			OP_REM_PUB: begin
				if (s < 0) st = ST_NOTFOUND;
				else begin
					foreach (sv[i])
						if (sub_sees(i, t.id, px[s], py[s])) push_ev(sid[i], EV_REMOVE);
					pv[s] = 0;
				end
			end
			OP_REM_SUB: begin
				if (s < 0) st = ST_NOTFOUND;
				else begin
					foreach (pv[i])
						if (pub_seen(i, t.id, sx[s], sy[s], sr[s])) push_ev(pid[i], EV_REMOVE);
					sv[s] = 0;
				end
			end
			OP_MOV_PUB: begin
				foreach (sv[i])
					if (sub_sees(i, t.id, nx, ny) && !sub_sees(i, t.id, ox, oy))
						push_ev(sid[i], EV_ADD);
				foreach (sv[i])
					if (!sub_sees(i, t.id, nx, ny) && sub_sees(i, t.id, ox, oy))
						push_ev(sid[i], EV_REMOVE);
				foreach (sv[i])
					if (sub_sees(i, t.id, nx, ny) && sub_sees(i, t.id, ox, oy))
						push_ev(sid[i], EV_MOVE);
				if (s < 0) st = ST_NOTFOUND;
				else begin px[s] = nx; py[s] = ny; end
			end
			OP_MOV_SUB: begin
				foreach (pv[i])
					if (pub_seen(i, t.id, nx, ny, r) && !pub_seen(i, t.id, ox, oy, r))
						push_ev(pid[i], EV_ADD);
				foreach (pv[i])
					if (!pub_seen(i, t.id, nx, ny, r) && pub_seen(i, t.id, ox, oy, r))
						push_ev(pid[i], EV_REMOVE);
				if (s < 0) st = ST_NOTFOUND;
				else begin sx[s] = nx; sy[s] = ny; sr[s] = r; end
			end
			default: ;
		endcase
		d.peer = '0; d.kind = EV_DONE; d.st = st; d.fin = 1;
		expect_ev(d);
	endfunction

	function automatic op_item_t mk(logic [2:0] op, logic [15:0] id, int nx, int ny,
			int ox, int oy, int rad);
		op_item_t t;
		t.op = op; t.id = id; t.nx = 16'(nx); t.ny = 16'(ny); t.ox = 16'(ox);
		t.oy = 16'(oy); t.rad = 15'(rad);
		return t;
	endfunction

	// Small id pool and a clustered playfield keep hits frequent.
	function automatic op_item_t rand_op();
		op_item_t t;
		int spread;
		t.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		t.id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		spread = ($urandom_range(0, 7) == 0) ? 32767 : 300;
		t.nx = 16'($urandom_range(0, 2 * spread) - spread);
		t.ny = 16'($urandom_range(0, 2 * spread) - spread);
		t.ox = 16'($urandom_range(0, 2 * spread) - spread);
		t.oy = 16'($urandom_range(0, 2 * spread) - spread);
		t.rad = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 400));
		if ($urandom_range(0, 15) == 0) begin
			t.nx = 16'($urandom); t.ny = 16'($urandom);
			t.ox = 16'($urandom); t.oy = 16'($urandom);
		end
		return t;
	endfunction

	// put the next pending item on the input ports
	task automatic drive_next();
		op_item_t t;
		t = pending_ops.pop_front();
		opcode <= t.op; entity_id <= t.id; pos_x <= t.nx; pos_y <= t.ny;
		old_x <= t.ox; old_y <= t.oy; view_range <= t.rad;
		in_valid <= 1;
	endtask

	// Driver: take the next item off the queue, hold it until accepted.
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_tracker(mk(opcode, entity_id, pos_x, pos_y, old_x, old_y, view_range));
				if (!quiet && $urandom_range(0, 3) == 0) begin
					in_valid <= 0;
					in_gap <= $urandom_range(0, 15);
				end else if (pending_ops.size() > 0) drive_next();
				else in_valid <= 0;
			end else if (!in_valid) begin
				if (in_gap > 0) in_gap <= in_gap - 1;
				else if (pending_ops.size() > 0) drive_next();
			end
		end
	end

	// Monitor plus receiver stalls.
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				event_t e;
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result peer=%0d kind=%0d",
						peer_id, event_kind);
				end else begin
					e = expected_events.pop_front();
					if (e.peer !== peer_id || e.kind !== event_kind || e.st !== status
							|| e.fin !== last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp peer=%0d kind=%0d st=%0d last=%0d got %0d %0d %0d %0d",
								e.peer, e.kind, e.st, e.fin, peer_id, event_kind, status, last);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_gap <= $urandom_range(0, 15);
				out_ready <= 0;
			end else out_ready <= 1;
			// watchdog on accepted traffic
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// directed: extremes, every opcode, not-found, self id, overwrite
		queue_op(mk(OP_REM_PUB, 16'd5, 0, 0, 0, 0, 0));
		queue_op(mk(OP_REM_SUB, 16'hFFFF, 0, 0, 0, 0, 0));
		queue_op(mk(OP_ADD_SUB, 16'd1, 0, 0, 0, 0, 15'h7FFF));
		queue_op(mk(OP_ADD_PUB, 16'd1, 10, 10, 0, 0, 0));
		queue_op(mk(OP_ADD_PUB, 16'd2, -32768, -32768, 0, 0, 0));
		queue_op(mk(OP_ADD_SUB, 16'hFFFF, 32767, 32767, 0, 0, 15'h7FFF));
		queue_op(mk(OP_ADD_SUB, 16'd0, -32768, 32767, 0, 0, 0));
		queue_op(mk(OP_ADD_PUB, 16'd3, -32768, 32767, 0, 0, 0));
		queue_op(mk(OP_MOV_PUB, 16'd2, 100, 0, -32768, -32768, 0));
		queue_op(mk(OP_MOV_PUB, 16'd9, 5, 5, 32767, 32767, 0));
		queue_op(mk(OP_MOV_SUB, 16'd1, 32767, 32767, 0, 0, 15'd50));
		queue_op(mk(OP_MOV_SUB, 16'd77, 0, 0, 32767, -32768, 15'h7FFF));
		queue_op(mk(OP_ADD_PUB, 16'd2, 0, 0, 0, 0, 0));
		queue_op(mk(3'd6, 16'd1, 0, 0, 0, 0, 0));
		queue_op(mk(3'd7, 16'hFFFF, -1, -1, -1, -1, 15'h7FFF));
		queue_op(mk(OP_REM_SUB, 16'd1, 0, 0, 0, 0, 0));
		queue_op(mk(OP_REM_PUB, 16'd3, 0, 0, 0, 0, 0));
		// fill both tables past full, then drain part of each
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			queue_op(mk(OP_ADD_PUB, 16'(100 + i), i, -i, 0, 0, 0));
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			queue_op(mk(OP_ADD_SUB, 16'(200 + i), -i, i, 0, 0, 15'(i * 3)));
		for (int i = 0; i < TABLE_DEPTH; i += 2)
			queue_op(mk(OP_REM_PUB, 16'(100 + i), 0, 0, 0, 0, 0));
		for (int i = 0; i < TABLE_DEPTH; i += 2)
			queue_op(mk(OP_REM_SUB, 16'(200 + i), 0, 0, 0, 0, 0));
		for (int i = 0; i < 230; i++) queue_op(rand_op());
		repeat (10) @(posedge clk);
		arst_n <= 1;
		while (pending_ops.size() > 40) @(posedge clk);
		quiet = 1;
		while (pending_ops.size() > 0 || in_valid) @(posedge clk);
		while (expected_events.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_events.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/eirt_pkg.sv
hdl/eirt_cell.sv
hdl/eirt_dist.sv
hdl/euclidean_interest_range_tracker_core.sv
tb/sv/tb_top.sv
